// ----- sv/servo_slew_pulse_setpoint_defines.svh -----
// assertion helpers for the servo slew setpoint block
`ifndef SERVO_SLEW_PULSE_SETPOINT_DEFINES_SVH
`define SERVO_SLEW_PULSE_SETPOINT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SSP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ssp check failed");

// next-cycle implication, checked outside reset
`define SSP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ssp check failed");

`endif

// ----- sv/ssp_pkg.sv -----
package ssp_pkg;

   localparam int CHANNELS        = 4;
   localparam int CMD_W           = 1;
   localparam int CHANNEL_W       = 2;
   localparam int ANGLE_W         = 13;
   localparam int MAX_ANGLE_W     = 9;
   localparam int COMPARE_W       = 12;
   localparam int CH_IDX_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [CMD_W-1:0] CMD_SET  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_STEP = 1'b1;

   localparam logic [MAX_ANGLE_W-1:0] MAX_ANGLE_RESET = 9'd180;
   localparam logic [MAX_ANGLE_W-1:0] MAX_ANGLE_LIMIT = 9'd360;

   // angle is in 1/16 degree, so 2000/16 = 125 per unit
   localparam int SCALE_W     = 7;
   localparam logic [SCALE_W-1:0] PULSE_SCALE = 7'd125;
   localparam logic [COMPARE_W-1:0] PULSE_BASE = 12'd500;
   localparam logic [COMPARE_W-1:0] PULSE_TOP  = 12'd2500;
   localparam logic [ANGLE_W-1:0] ANGLE_TOP    = 13'd5760;

   localparam int DIVIDEND_W  = ANGLE_W + SCALE_W;
   localparam int QUOTIENT_W  = 11;
   localparam int DIV_STEPS   = DIVIDEND_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } ssp_state_type;

   typedef struct packed {
      logic load;      // accept item, update angle
      logic mul;       // form the scaled dividend
      logic div_step;  // one restoring division step
      logic out_load;  // capture result into output registers
   } ssp_cmd_type;

   typedef struct packed {
      logic div_last;
   } ssp_status_type;

endpackage

// ----- sv/ssp_ctrl.sv -----
module ssp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  ssp_pkg::ssp_status_type status,
   output ssp_pkg::ssp_cmd_type    cmd
);
   import ssp_pkg::*;

   ssp_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- sv/ssp_datapath.sv -----
module ssp_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ssp_pkg::ssp_cmd_type                 cmd,
   output ssp_pkg::ssp_status_type              status,
   input  logic                                 csr_write,
   input  logic [ssp_pkg::MAX_ANGLE_W-1:0]      csr_max_angle,
   input  logic [ssp_pkg::CMD_W-1:0]            req_command,
   input  logic [ssp_pkg::CHANNEL_W-1:0]        req_channel,
   input  logic [ssp_pkg::ANGLE_W-1:0]          req_target_angle,
   input  logic [ssp_pkg::ANGLE_W-1:0]          req_step_size,
   output logic [ssp_pkg::CHANNEL_W-1:0]        rsp_out_channel,
   output logic [ssp_pkg::COMPARE_W-1:0]        rsp_compare_value,
   output logic [ssp_pkg::ANGLE_W-1:0]          rsp_current_angle,
   output logic                                 rsp_reached
);
   import ssp_pkg::*;

   logic [MAX_ANGLE_W-1:0] max_angle_ff;
   logic [ANGLE_W-1:0]     angles_ff [CHANNELS];

   logic [CHANNEL_W-1:0]   channel_ff;
   logic [ANGLE_W-1:0]     nxt_ff;
   logic                   reached_ff;
   logic [MAX_ANGLE_W-1:0] mdeg_ff;

   logic [MAX_ANGLE_W-1:0] rem_ff;
   logic [DIVIDEND_W-1:0]  dq_ff;
   logic [DIV_CNT_W-1:0]   cnt_ff;

   logic [CHANNEL_W-1:0]   out_channel_ff;
   logic [COMPARE_W-1:0]   out_compare_ff;
   logic [ANGLE_W-1:0]     out_angle_ff;
   logic                   out_reached_ff;

   logic [MAX_ANGLE_W-1:0] mdeg;
   logic [ANGLE_W-1:0]     lim;
   logic [CH_IDX_W-1:0]    ch_idx;
   logic                   ch_ok;
   logic [ANGLE_W-1:0]     cur;
   logic [ANGLE_W-1:0]     tgt_clamped;
   logic [ANGLE_W-1:0]     diff;
   logic [ANGLE_W:0]       up_sum;
   logic [ANGLE_W-1:0]     down_val;
   logic [ANGLE_W-1:0]     nxt;
   logic                   reached;

   logic [MAX_ANGLE_W:0]   trial;
   logic                   trial_ge;
   logic [COMPARE_W-1:0]   compare;

   // effective max in degrees: zero acts as 1, above the limit acts as the limit
   always_comb begin
      mdeg = max_angle_ff;
      if (mdeg == '0) begin
         mdeg = MAX_ANGLE_W'(1);
      end
      if (mdeg > MAX_ANGLE_LIMIT) begin
         mdeg = MAX_ANGLE_LIMIT;
      end
   end

   assign lim         = {mdeg, 4'b0000};
   assign ch_idx      = req_channel[CH_IDX_W-1:0];
   assign ch_ok       = int'(req_channel) < CHANNELS;
   assign cur         = angles_ff[ch_idx];
   assign tgt_clamped = (req_target_angle > lim) ? lim : req_target_angle;
   assign diff        = (cur > req_target_angle) ? (cur - req_target_angle)
                                                 : (req_target_angle - cur);
   assign up_sum      = {1'b0, cur} + {1'b0, req_step_size};
   assign down_val    = cur - req_step_size;

   always_comb begin
      nxt     = '0;
      reached = 1'b0;
      if (!ch_ok) begin
         nxt     = '0;
         reached = 1'b0;
      end else if (req_command == CMD_SET) begin
         nxt     = tgt_clamped;
         reached = 1'b1;
      end else if (diff < req_step_size) begin
         nxt     = tgt_clamped;
         reached = 1'b1;
      end else if (cur < req_target_angle) begin
         nxt = (up_sum > {1'b0, lim}) ? lim : up_sum[ANGLE_W-1:0];
      end else if (cur > req_target_angle) begin
         nxt = (down_val > lim) ? lim : down_val;
      end else begin
         nxt = (cur > lim) ? lim : cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_angle_ff <= MAX_ANGLE_RESET;
         for (int i = 0; i < CHANNELS; i++) begin
            angles_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            max_angle_ff <= csr_max_angle;
         end
         if (cmd.load && ch_ok) begin
            angles_ff[ch_idx] <= nxt;
         end
      end
   end

   // restoring divider, one quotient bit per step
   assign trial    = {rem_ff, dq_ff[DIVIDEND_W-1]};
   assign trial_ge = trial >= {1'b0, mdeg_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         channel_ff <= req_channel;
         nxt_ff     <= nxt;
         reached_ff <= reached;
         mdeg_ff    <= mdeg;
      end
      if (cmd.mul) begin
         dq_ff  <= DIVIDEND_W'(nxt_ff * PULSE_SCALE);
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         if (trial_ge) begin
            rem_ff <= MAX_ANGLE_W'(trial - {1'b0, mdeg_ff});
         end else begin
            rem_ff <= trial[MAX_ANGLE_W-1:0];
         end
         dq_ff  <= {dq_ff[DIVIDEND_W-2:0], trial_ge};
         cnt_ff <= cnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.out_load) begin
         out_channel_ff <= channel_ff;
         out_compare_ff <= compare;
         out_angle_ff   <= nxt_ff;
         out_reached_ff <= reached_ff;
      end
   end

   assign compare = COMPARE_W'(dq_ff[QUOTIENT_W-1:0]) + PULSE_BASE;

   assign status.div_last = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   assign rsp_out_channel   = out_channel_ff;
   assign rsp_compare_value = out_compare_ff;
   assign rsp_current_angle = out_angle_ff;
   assign rsp_reached       = out_reached_ff;

endmodule

// ----- sv/servo_slew_pulse_setpoint.sv -----
// servo slew setpoint: keeps one angle per servo channel and turns it into a
// pulse compare value (microsecond ticks, 500 to 2500).
// req channel: command (set or step), channel, target_angle, step_size; an
// item is taken when req_valid is high and req_stall is low.
// rsp channel: out_channel, compare_value, current_angle, reached; one item
// per request, taken when rsp_valid is high and rsp_stall is low.
// csr channel: csr_max_angle in whole degrees, written on csr_valid with
// csr_ready, which is always high; write it only while the block is idle.
// after the accepting edge, which updates the angle, an item passes through
// the scaling multiply, the divider steps by max_angle and the output load.
// with one divider, a new item is taken only once the last one is handed to the output register.
// req_stall is high from the cycle after an item is taken until it is handed
// to the output register.
// when the receiver stalls, the result stays in the output register; a
// finished next item then waits until that register is taken.
// reset: all channel angles go to 0, max_angle to 180, no response pending.
`include "servo_slew_pulse_setpoint_defines.svh"

module servo_slew_pulse_setpoint (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ssp_pkg::CMD_W-1:0]            req_command,
   input  logic [ssp_pkg::CHANNEL_W-1:0]        req_channel,
   input  logic [ssp_pkg::ANGLE_W-1:0]          req_target_angle,
   input  logic [ssp_pkg::ANGLE_W-1:0]          req_step_size,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ssp_pkg::CHANNEL_W-1:0]        rsp_out_channel,
   output logic [ssp_pkg::COMPARE_W-1:0]        rsp_compare_value,
   output logic [ssp_pkg::ANGLE_W-1:0]          rsp_current_angle,
   output logic                                 rsp_reached,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ssp_pkg::MAX_ANGLE_W-1:0]      csr_max_angle
);
   import ssp_pkg::*;

   ssp_cmd_type    cmd;
   ssp_status_type status;
   logic           pulse_in_range;

   assign csr_ready = 1'b1;

   ssp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ssp_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write         (csr_valid && csr_ready),
      .csr_max_angle     (csr_max_angle),
      .req_command       (req_command),
      .req_channel       (req_channel),
      .req_target_angle  (req_target_angle),
      .req_step_size     (req_step_size),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_compare_value (rsp_compare_value),
      .rsp_current_angle (rsp_current_angle),
      .rsp_reached       (rsp_reached)
   );

   assign pulse_in_range = (rsp_compare_value >= PULSE_BASE) &&
                           (rsp_compare_value <= PULSE_TOP);

   // busy right after an item is taken
   `SSP_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   // pulse stays within the servo range
   `SSP_ASSERT_NOW(a_compare_range, rsp_valid, pulse_in_range)
   // reported angle is always clamped
   `SSP_ASSERT_NOW(a_angle_range, rsp_valid, rsp_current_angle <= ANGLE_TOP)
   // zero angle maps to the base pulse
   `SSP_ASSERT_NOW(a_zero_base, rsp_valid && (rsp_current_angle == '0), rsp_compare_value == PULSE_BASE)

endmodule

// ----- tb/tb_servo_slew_pulse_setpoint.sv -----
`timescale 1ns / 1ps

module tb_servo_slew_pulse_setpoint;
   import ssp_pkg::*;

   localparam int IDLE_LIMIT    = 4000;
   localparam int RANDOM_ITEMS  = 850;
   localparam int DIRECTED_ROWS = 25;
   localparam int PRINT_LIMIT   = 100;
   localparam int TAIL_CYCLES   = 40;
   localparam int SLEW_MAX_LEN  = 12;

   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [CHANNEL_W-1:0] channel;
      logic [ANGLE_W-1:0]   target;
      logic [ANGLE_W-1:0]   step_size;
   } servo_req_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [COMPARE_W-1:0] compare;
      logic [ANGLE_W-1:0]   angle;
      logic                 reached;
   } pulse_result_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [MAX_ANGLE_W-1:0] max_deg;
      logic [CMD_W-1:0]     command;
      logic [CHANNEL_W-1:0] channel;
      logic [ANGLE_W-1:0]   target;
      logic [ANGLE_W-1:0]   step_size;
      logic                 typed;
      logic [COMPARE_W-1:0] compare;
      logic [ANGLE_W-1:0]   angle;
      logic                 reached;
   } directed_row_type;

   // kind, max_deg, command, channel, target, step, typed, compare, angle, reached
   // max angle starts at 180 degrees, so the angle limit is 2880
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_ITEM, 9'd0,   CMD_SET,  2'd0, 13'd0,    13'd0,    1'b1, 12'd500,  13'd0,    1'b1},
      '{ROW_ITEM, 9'd0,   CMD_SET,  2'd1, 13'd2880, 13'd0,    1'b1, 12'd2500, 13'd2880, 1'b1},
      '{ROW_ITEM, 9'd0,   CMD_SET,  2'd2, 13'd8191, 13'd8191, 1'b1, 12'd2500, 13'd2880, 1'b1},
      '{ROW_ITEM, 9'd0,   CMD_SET,  2'd3, 13'd1440, 13'd0,    1'b1, 12'd1500, 13'd1440, 1'b1},
      // zero step while already at the target
      '{ROW_ITEM, 9'd0,   CMD_STEP, 2'd0, 13'd0,    13'd0,    1'b1, 12'd500,  13'd0,    1'b0},
      '{ROW_ITEM, 9'd0,   CMD_STEP, 2'd0, 13'd2880, 13'd100,  1'b1, 12'd569,  13'd100,  1'b0},
      '{ROW_ITEM, 9'd0,   CMD_STEP, 2'd0, 13'd2880, 13'd8191, 1'b1, 12'd2500, 13'd2880, 1'b1},
      '{ROW_ITEM, 9'd0,   CMD_STEP, 2'd1, 13'd0,    13'd5760, 1'b1, 12'd500,  13'd0,    1'b1},
      '{ROW_ITEM, 9'd0,   CMD_STEP, 2'd3, 13'd1440, 13'd0,    1'b1, 12'd1500, 13'd1440, 1'b0},
      // step past the limit is clamped
      '{ROW_ITEM, 9'd0,   CMD_STEP, 2'd2, 13'd5760, 13'd1,    1'b1, 12'd2500, 13'd2880, 1'b0},
      '{ROW_ITEM, 9'd0,   CMD_STEP, 2'd3, 13'd8191, 13'd4095, 1'b1, 12'd2500, 13'd2880, 1'b0},
      '{ROW_ITEM, 9'd0,   CMD_STEP, 2'd3, 13'd0,    13'd1000, 1'b0, 12'd0,    13'd0,    1'b0},
      // zero max angle acts as one degree
      '{ROW_CSR,  9'd0,   CMD_SET,  2'd0, 13'd0,    13'd0,    1'b0, 12'd0,    13'd0,    1'b0},
      // stale angle gets clamped on its next update
      '{ROW_ITEM, 9'd0,   CMD_STEP, 2'd3, 13'd1880, 13'd0,    1'b1, 12'd2500, 13'd16,   1'b0},
      '{ROW_ITEM, 9'd0,   CMD_SET,  2'd0, 13'd8191, 13'd0,    1'b1, 12'd2500, 13'd16,   1'b1},
      '{ROW_ITEM, 9'd0,   CMD_STEP, 2'd1, 13'd16,   13'd3,    1'b0, 12'd0,    13'd0,    1'b0},
      // max angle above the limit acts as 360
      '{ROW_CSR,  9'd511, CMD_SET,  2'd0, 13'd0,    13'd0,    1'b0, 12'd0,    13'd0,    1'b0},
      '{ROW_ITEM, 9'd0,   CMD_SET,  2'd1, 13'd5760, 13'd0,    1'b1, 12'd2500, 13'd5760, 1'b1},
      '{ROW_ITEM, 9'd0,   CMD_STEP, 2'd2, 13'd8191, 13'd8191, 1'b1, 12'd2500, 13'd5760, 1'b1},
      '{ROW_ITEM, 9'd0,   CMD_STEP, 2'd1, 13'd0,    13'd4096, 1'b0, 12'd0,    13'd0,    1'b0},
      '{ROW_CSR,  9'd1,   CMD_SET,  2'd0, 13'd0,    13'd0,    1'b0, 12'd0,    13'd0,    1'b0},
      '{ROW_ITEM, 9'd0,   CMD_SET,  2'd0, 13'd7,    13'd0,    1'b1, 12'd1375, 13'd7,    1'b1},
      '{ROW_CSR,  9'd361, CMD_SET,  2'd0, 13'd0,    13'd0,    1'b0, 12'd0,    13'd0,    1'b0},
      '{ROW_ITEM, 9'd0,   CMD_STEP, 2'd0, 13'd5760, 13'd2047, 1'b0, 12'd0,    13'd0,    1'b0},
      '{ROW_CSR,  9'd360, CMD_SET,  2'd0, 13'd0,    13'd0,    1'b0, 12'd0,    13'd0,    1'b0}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [CMD_W-1:0]       req_command;
   logic [CHANNEL_W-1:0]   req_channel;
   logic [ANGLE_W-1:0]     req_target_angle;
   logic [ANGLE_W-1:0]     req_step_size;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [CHANNEL_W-1:0]   rsp_out_channel;
   logic [COMPARE_W-1:0]   rsp_compare_value;
   logic [ANGLE_W-1:0]     rsp_current_angle;
   logic                   rsp_reached;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [MAX_ANGLE_W-1:0] csr_max_angle;

   // predictor state
   logic [ANGLE_W-1:0]     servo_angle [CHANNELS];
   logic [MAX_ANGLE_W-1:0] max_angle_deg;

   pulse_result_type       pending_pulses [$];
   pulse_result_type       last_pulse;
   int                     items_accepted = 0;
   int                     mismatches = 0;
   int                     quiet_cycles = 0;
   int                     gap_pct = 0;
   int                     stall_pct = 0;

   servo_slew_pulse_setpoint DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_channel       (req_channel),
      .req_target_angle  (req_target_angle),
      .req_step_size     (req_step_size),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_compare_value (rsp_compare_value),
      .rsp_current_angle (rsp_current_angle),
      .rsp_reached       (rsp_reached),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_max_angle     (csr_max_angle)
   );

   always #5 clock = ~clock;

   function automatic int unsigned effective_max_deg();
      int unsigned deg;
      deg = 32'(max_angle_deg);
      if (deg == 0) deg = 1;
      if (deg > 32'(MAX_ANGLE_LIMIT)) deg = 32'(MAX_ANGLE_LIMIT);
      return deg;
   endfunction

   function automatic pulse_result_type predict_setpoint(input servo_req_type r);
      int unsigned deg, lim, cur, tgt, stride, delta, nxt;
      pulse_result_type p;
      deg = effective_max_deg();
      lim = deg * 16;
      tgt = 32'(r.target);
      stride = 32'(r.step_size);
      p.channel = r.channel;
      p.reached = 1'b0;
      if (r.channel >= CHANNELS) begin
         p.compare = PULSE_BASE;
         p.angle = '0;
         return p;
      end
      cur = 32'(servo_angle[r.channel]);
      if (r.command == CMD_SET) begin
         nxt = tgt;
         p.reached = 1'b1;
      end else begin
         delta = (cur > tgt) ? cur - tgt : tgt - cur;
         if (delta < stride) begin
            nxt = tgt;
            p.reached = 1'b1;
         end else if (cur < tgt) begin
            nxt = cur + stride;
         end else if (cur > tgt) begin
            nxt = cur - stride;
         end else begin
            nxt = cur;
         end
      end
      if (nxt > lim) nxt = lim;
      servo_angle[r.channel] = nxt[ANGLE_W-1:0];
      p.angle = nxt[ANGLE_W-1:0];
      p.compare = COMPARE_W'((nxt * PULSE_SCALE) / deg + PULSE_BASE);
      return p;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic send_req(input servo_req_type r, input logic typed,
                           input pulse_result_type want);
      pulse_result_type guess;
      req_valid <= 1'b1;
      req_command <= r.command;
      req_channel <= r.channel;
      req_target_angle <= r.target;
      req_step_size <= r.step_size;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      guess = predict_setpoint(r);
      pending_pulses.push_back(typed ? want : guess);
      last_pulse = guess;
      items_accepted++;
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // register writes only once every item has come back
   task automatic write_max_angle(input logic [MAX_ANGLE_W-1:0] deg);
      req_valid <= 1'b0;
      while (pending_pulses.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_max_angle <= deg;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      max_angle_deg = deg;
   endtask

   task automatic run_random(input int count);
      int goal, block_end, lim, n;
      logic [MAX_ANGLE_W-1:0] deg;
      servo_req_type r;
      goal = items_accepted + count;
      while (items_accepted < goal) begin
         case ($urandom_range(0, 7))
            0: deg = '0;
            1: deg = 9'd1;
            2: deg = MAX_ANGLE_RESET;
            3: deg = MAX_ANGLE_LIMIT;
            4: deg = MAX_ANGLE_LIMIT + 9'd1;
            5: deg = '1;
            6: deg = MAX_ANGLE_W'($urandom_range(1, MAX_ANGLE_LIMIT));
            default: deg = MAX_ANGLE_W'($urandom_range(0, 511));
         endcase
         write_max_angle(deg);
         block_end = items_accepted + $urandom_range(40, 80);
         if (block_end > goal) block_end = goal;
         while (items_accepted < block_end) begin
            r.channel = CHANNEL_W'($urandom_range(0, CHANNELS - 1));
            if ($urandom_range(0, 99) < 70) begin
               // slew run: step one channel until it lands on its target, at most SLEW_MAX_LEN steps
               lim = effective_max_deg() * 16;
               if ($urandom_range(0, 3) == 0) begin
                  r.command = CMD_SET;
                  r.target = ANGLE_W'($urandom_range(0, lim));
                  r.step_size = ANGLE_W'($urandom_range(0, 8191));
                  send_req(r, 1'b0, '0);
               end
               r.command = CMD_STEP;
               r.target = ($urandom_range(0, 9) == 0) ? ANGLE_W'($urandom_range(0, 8191))
                                                      : ANGLE_W'($urandom_range(0, lim));
               r.step_size = ($urandom_range(0, 4) == 0)
                             ? ANGLE_W'($urandom_range(0, 8191))
                             : ANGLE_W'($urandom_range(1, 800));
               n = 0;
               do begin
                  send_req(r, 1'b0, '0);
                  n++;
               end while (!last_pulse.reached && n < SLEW_MAX_LEN);
            end else begin
               r.command = $urandom_range(0, 1) ? CMD_STEP : CMD_SET;
               r.target = ANGLE_W'($urandom_range(0, 8191));
               case ($urandom_range(0, 2))
                  0: r.step_size = '0;
                  1: r.step_size = ANGLE_W'($urandom_range(0, 15));
                  default: r.step_size = ANGLE_W'($urandom_range(0, 8191));
               endcase
               send_req(r, 1'b0, '0);
            end
         end
      end
   endtask

   always @(posedge clock) rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   always @(posedge clock) begin
      pulse_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pulses.size() == 0) begin
            report_mismatch($sformatf("unexpected item ch %0d compare %0d angle %0d",
                                      rsp_out_channel, rsp_compare_value, rsp_current_angle));
         end else begin
            exp_r = pending_pulses.pop_front();
            if (rsp_out_channel !== exp_r.channel)
               report_mismatch($sformatf("out_channel %0d, expected %0d",
                                         rsp_out_channel, exp_r.channel));
            if (rsp_compare_value !== exp_r.compare)
               report_mismatch($sformatf("compare_value %0d, expected %0d (ch %0d)",
                                         rsp_compare_value, exp_r.compare, exp_r.channel));
            if (rsp_current_angle !== exp_r.angle)
               report_mismatch($sformatf("current_angle %0d, expected %0d (ch %0d)",
                                         rsp_current_angle, exp_r.angle, exp_r.channel));
            if (rsp_reached !== exp_r.reached)
               report_mismatch($sformatf("reached %0b, expected %0b (ch %0d)",
                                         rsp_reached, exp_r.reached, exp_r.channel));
         end
      end
   end

   // watchdog: cycles in which no item moves on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      directed_row_type row;
      servo_req_type    r;
      pulse_result_type want;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_SET;
      req_channel = '0;
      req_target_angle = '0;
      req_step_size = '0;
      csr_valid = 1'b0;
      csr_max_angle = '0;
      max_angle_deg = MAX_ANGLE_RESET;
      foreach (servo_angle[i]) servo_angle[i] = '0;
      gap_pct = 14;
      stall_pct = 48;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            write_max_angle(row.max_deg);
         end else begin
            r.command = row.command;
            r.channel = row.channel;
            r.target = row.target;
            r.step_size = row.step_size;
            want.channel = row.channel;
            want.compare = row.compare;
            want.angle = row.angle;
            want.reached = row.reached;
            send_req(r, row.typed, want);
         end
      end

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               gap_pct = 14;
               stall_pct = 48;
            end
            1: begin
               gap_pct = 48;
               stall_pct = 14;
            end
            default: begin
               gap_pct = 0;
               stall_pct = 0;
            end
         endcase
         run_random((ph == 2) ? RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3) : RANDOM_ITEMS / 3);
      end

      req_valid <= 1'b0;
      while (pending_pulses.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- servo_slew_pulse_setpoint.f -----
+incdir+sv
sv/ssp_pkg.sv
sv/ssp_ctrl.sv
sv/ssp_datapath.sv
sv/servo_slew_pulse_setpoint.sv
tb/tb_servo_slew_pulse_setpoint.sv
